FILE: src/tsgd_pkg.sv
package tsgd_pkg;

  localparam int COORD_W = 12;

  // Raw event codes on the action port
  localparam logic [2:0] ACT_PRESS   = 3'd0;
  localparam logic [2:0] ACT_RELEASE = 3'd1;
  localparam logic [2:0] ACT_X       = 3'd2;
  localparam logic [2:0] ACT_Y       = 3'd3;

  // Gesture codes on the result
  localparam logic [2:0] GEST_NONE  = 3'd0;
  localparam logic [2:0] GEST_LEFT  = 3'd1;
  localparam logic [2:0] GEST_RIGHT = 3'd2;
  localparam logic [2:0] GEST_UP    = 3'd3;
  localparam logic [2:0] GEST_DOWN  = 3'd4;

  // Largest scaled coordinates
  localparam logic [COORD_W-1:0] MAX_X = 12'd3199;
  localparam logic [COORD_W-1:0] MAX_Y = 12'd3276;

  typedef enum logic [1:0] {
    KIND_PRESS,
    KIND_RELEASE,
    KIND_X,
    KIND_Y
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [COORD_W-1:0] value;
  } cmd_t;

endpackage

FILE: src/tsgd_queue.sv
module tsgd_queue import tsgd_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t               entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

FILE: src/tsgd_front.sv
module tsgd_front import tsgd_pkg::*; (
  input  logic               evt_valid,
  output logic               evt_stall,
  input  logic [2:0]         action,
  input  logic [COORD_W-1:0] raw_value,
  input  logic               full,
  output logic               push,
  output cmd_t               push_cmd
);

  logic [16:0] prod_x;
  logic [13:0] quad_y;
  logic [29:0] prod_y;
  logic        keep;

  // x * 800 / 1024 = x * 25 / 32
  assign prod_x = 17'(raw_value) * 17'd25;
  // y * 480 / 600 = 4y / 5; divide by 5 through the reciprocal 52429 / 2^18
  assign quad_y = {raw_value, 2'b00};
  assign prod_y = 30'(quad_y) * 30'd52429;

  always_comb begin
    keep           = 1'b1;
    push_cmd.kind  = KIND_PRESS;
    push_cmd.value = prod_x[16:5];
    case (action)
      ACT_PRESS:   push_cmd.kind = KIND_PRESS;
      ACT_RELEASE: push_cmd.kind = KIND_RELEASE;
      ACT_X:       push_cmd.kind = KIND_X;
      ACT_Y: begin
        push_cmd.kind  = KIND_Y;
        push_cmd.value = prod_y[29:18];
      end
      default:     keep = 1'b0;
    endcase
  end

  assign evt_stall = full;
  assign push      = evt_valid && !full && keep;

endmodule

FILE: src/tsgd_back.sv
module tsgd_back import tsgd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  cmd_t               head_cmd,
  output logic               pop,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [2:0]         gesture,
  output logic [COORD_W-1:0] end_x,
  output logic [COORD_W-1:0] end_y
);

  logic [COORD_W-1:0] start_x;
  logic [COORD_W-1:0] start_y;
  logic [COORD_W-1:0] last_x;
  logic [COORD_W-1:0] last_y;
  logic               have_x;
  logic               have_y;
  logic [COORD_W-1:0] dx;
  logic [COORD_W-1:0] dy;
  logic [2:0]         gesture_next;
  logic               out_free;
  logic               is_release;
  logic               load;

  assign dx = (start_x > last_x) ? start_x - last_x : last_x - start_x;
  assign dy = (start_y > last_y) ? start_y - last_y : last_y - start_y;

  always_comb begin
    gesture_next = GEST_NONE;
    if (dx > dy) begin
      gesture_next = (start_x > last_x) ? GEST_LEFT : GEST_RIGHT;
    end else if (dy > dx) begin
      gesture_next = (start_y > last_y) ? GEST_UP : GEST_DOWN;
    end
  end

  assign out_free   = !res_valid || !res_stall;
  assign is_release = (head_cmd.kind == KIND_RELEASE);
  assign pop        = head_valid && (!is_release || out_free);
  assign load       = pop && is_release;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= '0;
      start_y <= '0;
      last_x  <= '0;
      last_y  <= '0;
      have_x  <= 1'b0;
      have_y  <= 1'b0;
    end else if (pop) begin
      case (head_cmd.kind)
        KIND_PRESS: begin
          have_x <= 1'b0;
          have_y <= 1'b0;
        end
        KIND_RELEASE: begin
          start_x <= '0;
          start_y <= '0;
          last_x  <= '0;
          last_y  <= '0;
          have_x  <= 1'b0;
          have_y  <= 1'b0;
        end
        KIND_X: begin
          if (!have_x || !have_y) begin
            start_x <= head_cmd.value;
            have_x  <= 1'b1;
          end
          last_x <= head_cmd.value;
        end
        KIND_Y: begin
          if (!have_x || !have_y) begin
            start_y <= head_cmd.value;
            have_y  <= 1'b1;
          end
          last_y <= head_cmd.value;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      gesture <= gesture_next;
      end_x   <= last_x;
      end_y   <= last_y;
    end
  end

endmodule

FILE: src/touch_swipe_gesture_detector.sv
// Result path: an accepted release beat is written into the command queue, then
//   classified from the queue head into the result register.
// Throughput: one event beat per cycle; the front side stalls only when the
//   command queue is full, i.e. while a release waits behind a held result.
// Reset: rst is synchronous, active high; it empties the queue, clears the
//   touch state to zero and drops any pending result.
module touch_swipe_gesture_detector import tsgd_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               evt_valid,
  output logic               evt_stall,
  input  logic [2:0]         action,
  input  logic [COORD_W-1:0] raw_value,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [2:0]         gesture,
  output logic [COORD_W-1:0] end_x,
  output logic [COORD_W-1:0] end_y
);

  // Front: decode the action code, scale the raw coordinate, drop
  // unused codes, and push one command per kept beat.
  logic push;
  cmd_t push_cmd;
  logic full;

  // Queue to back: head command and pop handshake.
  logic head_valid;
  cmd_t head_cmd;
  logic pop;

  tsgd_front u_front (
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .action    (action),
    .raw_value (raw_value),
    .full      (full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // Short queue that lets the front keep taking beats while a finished
  // result waits in the back's output register.
  tsgd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Back: hold the touch state, update it per command, and on a release
  // classify the swipe into the output register and return to reset state.
  tsgd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .gesture    (gesture),
    .end_x      (end_x),
    .end_y      (end_y)
  );

endmodule

FILE: src/tsgd_checker.sv
module tsgd_checker import tsgd_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_stall,
  input logic [2:0]         gesture,
  input logic [COORD_W-1:0] end_x,
  input logic [COORD_W-1:0] end_y
);

  // Hold a stalled result beat.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(gesture) && $stable(end_x)
      && $stable(end_y))
    else $error("stalled result beat changed");

  // No result right after reset.
  assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result valid after reset");

  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> gesture <= GEST_DOWN)
    else $error("gesture code out of range");

  // Scaled coordinates stay on screen range.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (end_x <= MAX_X) && (end_y <= MAX_Y))
    else $error("end coordinate out of range");

endmodule

bind touch_swipe_gesture_detector tsgd_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .gesture   (gesture),
  .end_x     (end_x),
  .end_y     (end_y)
);

FILE: tb/touch_swipe_gesture_detector_tb.sv
`timescale 1ns / 1ps

module touch_swipe_gesture_detector_tb;
  import tsgd_pkg::*;

  // Action codes 4 to 7 have no meaning in the block and must be dropped
  localparam logic [2:0] ACT_UNUSED_FIRST = 3'd4;
  localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;
  localparam logic [COORD_W-1:0] RAW_MAX  = '1;

  localparam int EVENT_TARGET = 900;
  // Both sides run without idling once this many events have gone in
  localparam int QUIET_AFTER  = 780;
  localparam int LONG_HOLD    = 80;

  typedef struct packed {
    logic [2:0]         gesture;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
  } swipe_t;

  // Tracks the touch state the way the block should and holds the swipes
  // still owed by the block, oldest first.
  class swipe_scoreboard;
    logic [COORD_W-1:0] start_x, start_y, last_x, last_y;
    bit have_x, have_y;
    swipe_t swipes_due[$];
    int errors;
    int matched;
    int seen[5];

    function new();
      errors  = 0;
      matched = 0;
      foreach (seen[i]) seen[i] = 0;
      clear_touch();
    endfunction

    function void clear_touch();
      start_x = '0;
      start_y = '0;
      last_x  = '0;
      last_y  = '0;
      have_x  = 1'b0;
      have_y  = 1'b0;
    endfunction

    function logic [COORD_W-1:0] px_x(logic [COORD_W-1:0] v);
      int unsigned t;
      t = v;
      return COORD_W'((t * 800) / 1024);
    endfunction

    function logic [COORD_W-1:0] px_y(logic [COORD_W-1:0] v);
      int unsigned t;
      t = v;
      return COORD_W'((t * 480) / 600);
    endfunction

    function int pending();
      return swipes_due.size();
    endfunction

    task report(string msg);
      if (errors < 25) $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    // Advance the touch state by one accepted event beat
    function void note_event(logic [2:0] act, logic [COORD_W-1:0] raw);
      logic [COORD_W-1:0] p;
      int unsigned dx, dy;
      swipe_t s;
      case (act)
        ACT_PRESS: begin
          have_x = 1'b0;
          have_y = 1'b0;
        end
        ACT_X, ACT_Y: begin
          p = (act == ACT_X) ? px_x(raw) : px_y(raw);
          // The start point keeps moving until both axes have been seen
          if (!have_x || !have_y) begin
            if (act == ACT_X) begin
              start_x = p;
              have_x  = 1'b1;
            end else begin
              start_y = p;
              have_y  = 1'b1;
            end
          end
          if (act == ACT_X) last_x = p;
          else last_y = p;
        end
        ACT_RELEASE: begin
          dx = (start_x > last_x) ? start_x - last_x : last_x - start_x;
          dy = (start_y > last_y) ? start_y - last_y : last_y - start_y;
          s.gesture = GEST_NONE;
          if (dx > dy) s.gesture = (start_x > last_x) ? GEST_LEFT : GEST_RIGHT;
          else if (dy > dx) s.gesture = (start_y > last_y) ? GEST_UP : GEST_DOWN;
          s.end_x = last_x;
          s.end_y = last_y;
          swipes_due.push_back(s);
          clear_touch();
        end
        default: ;
      endcase
    endfunction

    // Compare one accepted result beat with the oldest swipe owed
    task check_result(logic [2:0] g, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      swipe_t want;
      if (swipes_due.size() == 0) begin
        report($sformatf("result with no release pending: gesture=%0d end=(%0d,%0d)",
                         g, x, y));
        return;
      end
      want = swipes_due.pop_front();
      if (g !== want.gesture)
        report($sformatf("gesture %0d, expected %0d", g, want.gesture));
      if (x !== want.end_x)
        report($sformatf("end_x %0d, expected %0d", x, want.end_x));
      if (y !== want.end_y)
        report($sformatf("end_y %0d, expected %0d", y, want.end_y));
      if (want.gesture <= GEST_DOWN) seen[int'(want.gesture)]++;
      matched++;
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               evt_valid;
  logic               evt_stall;
  logic [2:0]         action;
  logic [COORD_W-1:0] raw_value;
  logic               res_valid;
  logic               res_stall;
  logic [2:0]         gesture;
  logic [COORD_W-1:0] end_x;
  logic [COORD_W-1:0] end_y;

  swipe_scoreboard sb;

  int  events_sent;     // accepted beats with a meaningful action code
  int  ignored_sent;    // accepted beats with an unused action code
  bit  quiet;           // no idling on either side
  bit  sender_bursty;   // sender may insert idle bursts
  bit  long_hold_req;   // ask the receiver for one long hold-off
  bit  hold_done;       // the long hold-off phase has run
  bit  drain_done;      // the sender pause phase has run
  int  stall_peak;      // longest run of evt_stall seen while offering

  touch_swipe_gesture_detector uut (
    .clk      (clk),
    .rst      (rst),
    .evt_valid(evt_valid),
    .evt_stall(evt_stall),
    .action   (action),
    .raw_value(raw_value),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .gesture  (gesture),
    .end_x    (end_x),
    .end_y    (end_y)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample both channels at the edge, before any driver update lands.
  // Note the event first: a release result never shows in the same cycle.
  initial sb = new();

  always @(posedge clk) begin
    if (!rst) begin
      if (evt_valid && !evt_stall) sb.note_event(action, raw_value);
      if (res_valid && !res_stall) sb.check_result(gesture, end_x, end_y);
    end
  end

  // Receiver: random stall bursts in phases, one long hold-off on request,
  // and none at all in the quiet tail.
  initial begin
    int rate;
    int left_in_phase;
    res_stall     <= 1'b0;
    rate          = 0;
    left_in_phase = 0;
    forever begin
      @(posedge clk);
      if (left_in_phase == 0) begin
        rate          = $urandom_range(0, 3);
        left_in_phase = $urandom_range(40, 200);
      end else begin
        left_in_phase--;
      end
      if (long_hold_req) begin
        // Hold for a counted stretch so the queue fills and stalls the input
        res_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        res_stall <= 1'b0;
        long_hold_req = 1'b0;
      end else if (!quiet && rate != 0 && $urandom_range(0, 12 / rate) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        res_stall <= 1'b0;
      end
    end
  end

  // Watch how long the input side stays blocked while a beat is offered
  always @(posedge clk) begin
    int run;
    if (rst || !evt_valid || !evt_stall) run = 0;
    else begin
      run++;
      if (run > stall_peak) stall_peak = run;
    end
  end

  // Offer one event beat and hold it until accepted. An idle gap, if any,
  // lowers valid first so valid is never dropped and raised in one step.
  task send_event(logic [2:0] act, logic [COORD_W-1:0] raw);
    int gap;
    gap = 0;
    if (!quiet && sender_bursty && $urandom_range(0, 6) == 0) gap = $urandom_range(1, 14);
    if (gap > 0) begin
      evt_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    evt_valid <= 1'b1;
    action    <= act;
    raw_value <= raw;
    @(posedge clk);
    while (evt_stall) @(posedge clk);
    if (act >= ACT_UNUSED_FIRST) ignored_sent++;
    else events_sent++;
  endtask

  // Mix of full range, the rails and tiny values (tiny values make ties)
  function logic [COORD_W-1:0] pick_raw();
    case ($urandom_range(0, 7))
      0:       return ($urandom_range(0, 1) != 0) ? RAW_MAX : '0;
      1:       return COORD_W'($urandom_range(0, 7));
      default: return COORD_W'($urandom_range(0, 4095));
    endcase
  endfunction

  function logic [2:0] pick_unused();
    return 3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
  endfunction

  // Well-formed touch: press, a few moves with random content, release.
  // Now and then slip an unused code or a second press into the middle.
  task swipe(int max_moves);
    int n;
    send_event(ACT_PRESS, pick_raw());
    n = $urandom_range(1, max_moves);
    repeat (n) begin
      case ($urandom_range(0, 11))
        0:       send_event(pick_unused(), pick_raw());
        1:       send_event(ACT_PRESS, pick_raw());
        default: send_event(($urandom_range(0, 1) != 0) ? ACT_X : ACT_Y, pick_raw());
      endcase
    end
    send_event(ACT_RELEASE, pick_raw());
  endtask

  task wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    rst           <= 1'b1;
    evt_valid     <= 1'b0;
    action        <= ACT_PRESS;
    raw_value     <= '0;
    events_sent   = 0;
    ignored_sent  = 0;
    quiet         = 1'b0;
    sender_bursty = 1'b0;
    long_hold_req = 1'b0;
    hold_done     = 1'b0;
    drain_done    = 1'b0;
    stall_peak    = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: release with no motion straight out of reset
    send_event(ACT_RELEASE, RAW_MAX);
    // Unused codes at both ends of their range: drop, no result
    send_event(ACT_UNUSED_FIRST, RAW_MAX);
    send_event(ACT_UNUSED_LAST, '0);
    // Corner to corner: Y travel wins by a hair, swipe up
    send_event(ACT_PRESS, '0);
    send_event(ACT_X, '0);
    send_event(ACT_Y, RAW_MAX);
    send_event(ACT_X, RAW_MAX);
    send_event(ACT_Y, '0);
    send_event(ACT_RELEASE, '0);
    // Equal travel on both axes: no gesture
    send_event(ACT_PRESS, '0);
    send_event(ACT_X, 12'd1024);
    send_event(ACT_Y, 12'd1000);
    send_event(ACT_X, '0);
    send_event(ACT_Y, '0);
    send_event(ACT_RELEASE, '0);
    // Start recapture on X while Y is still unseen, then swipe right
    send_event(ACT_PRESS, '0);
    send_event(ACT_X, 12'd2048);
    send_event(ACT_X, 12'd100);
    send_event(ACT_Y, 12'd300);
    send_event(ACT_X, 12'd4000);
    send_event(ACT_RELEASE, '0);
    // Pure X travel to the left
    send_event(ACT_PRESS, RAW_MAX);
    send_event(ACT_X, RAW_MAX);
    send_event(ACT_Y, 12'd2000);
    send_event(ACT_X, '0);
    send_event(ACT_RELEASE, RAW_MAX);

    // Random part
    while (events_sent < EVENT_TARGET) begin
      if (events_sent >= QUIET_AFTER) quiet = 1'b1;
      sender_bursty = ($urandom_range(0, 2) != 0);

      if (!hold_done && events_sent >= 300) begin
        // Hold off the receiver while back-to-back short swipes keep coming
        hold_done     = 1'b1;
        sender_bursty = 1'b0;
        long_hold_req = 1'b1;
        repeat (5) begin
          send_event(ACT_PRESS, pick_raw());
          send_event(ACT_X, pick_raw());
          send_event(ACT_Y, pick_raw());
          send_event(ACT_RELEASE, pick_raw());
        end
      end else if (!drain_done && events_sent >= 600) begin
        // Pause the sender until every owed swipe has come out
        drain_done = 1'b1;
        evt_valid <= 1'b0;
        wait_drained();
        swipe(4);
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            // Noise: any code, any value
            send_event(3'($urandom_range(0, 7)), pick_raw());
          end
          1: begin
            // Broken touch: moves or presses with no clean start, maybe no release
            repeat ($urandom_range(1, 5)) begin
              case ($urandom_range(0, 3))
                0:       send_event(ACT_X, pick_raw());
                1:       send_event(ACT_Y, pick_raw());
                2:       send_event(ACT_PRESS, pick_raw());
                default: send_event(pick_unused(), pick_raw());
              endcase
            end
            if ($urandom_range(0, 1) != 0) send_event(ACT_RELEASE, pick_raw());
          end
          default: swipe(($urandom_range(0, 4) == 0) ? 12 : 5);
        endcase
      end
    end
    evt_valid <= 1'b0;

    // Drain, then let the pipeline settle in case a stray result is coming
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Covered %0d events plus %0d unused codes; %0d swipes checked", events_sent,
             ignored_sent, sb.matched);
    $display("Gestures none/left/right/up/down: %0d/%0d/%0d/%0d/%0d; longest input stall %0d",
             sb.seen[0], sb.seen[1], sb.seen[2], sb.seen[3], sb.seen[4], stall_peak);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #3_000_000;
    $display("Timeout with %0d swipes still owed", sb.pending());
    $display("Test completed with failures");
    $finish;
  end

endmodule
